[rtl/apr_pkg.sv]
`timescale 1ns / 1ps

package apr_pkg;

   localparam int DefaultMaxFrames = 16;
   localparam int QueueDepth       = 2;

   localparam int PageWidth  = 16;
   localparam int AgeWidth   = 16;
   localparam int CountWidth = 16;
   localparam int CfgWidth   = 5;
   localparam int IndexWidth = 4;

   localparam logic [CfgWidth-1:0] FramesReset = CfgWidth'(16);
   localparam logic [AgeWidth-1:0] AgeTopBit   = {1'b1, {(AgeWidth-1){1'b0}}};

   typedef struct packed {
      logic                  hit;
      logic [IndexWidth-1:0] frame_index;
      logic [CountWidth-1:0] hit_count;
      logic [CountWidth-1:0] miss_count;
   } apr_result_type;

endpackage

[rtl/apr_if.sv]
`timescale 1ns / 1ps

interface apr_req_if import apr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [PageWidth-1:0] page_id;

   modport source (output valid, output page_id, input ready);
   modport sink (input valid, input page_id, output ready);
endinterface

interface apr_rsp_if import apr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic [IndexWidth-1:0] frame_index;
   logic [CountWidth-1:0] hit_count;
   logic [CountWidth-1:0] miss_count;

   modport source (output valid, output hit, output frame_index, output hit_count,
                   output miss_count, input ready);
   modport sink (input valid, input hit, input frame_index, input hit_count,
                 input miss_count, output ready);
endinterface

[rtl/aging_page_replacement.sv]
`timescale 1ns / 1ps

// Channel    Direction  Transfer carries
// req_chan   in         page_id
// rsp_chan   out        hit, frame_index, hit_count, miss_count
// csr_write  in         frames_in_use (one write per enabled edge)
//
// In the back end a reference passes from idle, which issues the first frame
// read, through the scan, which ages and checks the n clamped frames one by
// one through the frame RAM port, to the update, which writes the chosen frame.
// Reset is synchronous; it empties all frames and clears both totals.
// A two-entry queue lets references arrive while the scan runs, and the
// result register lets the next reference start while a response stalls.
module aging_page_replacement import apr_pkg::*; #(
   parameter int MAX_FRAMES = DefaultMaxFrames
) (
   input  logic                clock,
   input  logic                reset,
   apr_req_if.sink             req_chan,
   apr_rsp_if.source           rsp_chan,
   input  logic                csr_write_en,
   input  logic [CfgWidth-1:0] csr_write_data
);
   localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int NW = IW + 1;
   localparam int QW = NW + PageWidth;
   localparam int MaxInFlight = QueueDepth + 2;
   localparam int OW = $clog2(MaxInFlight + 1);

   logic           push, pop, q_full, q_not_empty;
   logic [QW-1:0]  push_data, pop_data;
   apr_result_type result;
   logic [OW-1:0]  in_flight_ff, in_flight_in;
   logic           req_xfer, rsp_xfer;

   apr_front #(.MAX_FRAMES(MAX_FRAMES), .NW(NW)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .queue_full     (q_full),
      .push           (push),
      .push_data      (push_data)
   );

   apr_queue #(.WIDTH(QW), .DEPTH(QueueDepth)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .pop_data  (pop_data)
   );

   apr_back #(.MAX_FRAMES(MAX_FRAMES), .IW(IW), .NW(NW)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (pop_data),
      .q_pop       (pop),
      .out_valid   (rsp_chan.valid),
      .out_result  (result),
      .out_ready   (rsp_chan.ready)
   );

   assign rsp_chan.hit         = result.hit;
   assign rsp_chan.frame_index = result.frame_index;
   assign rsp_chan.hit_count   = result.hit_count;
   assign rsp_chan.miss_count  = result.miss_count;

   // References accepted but not yet answered, for the checks below.
   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_xfer = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      in_flight_in = in_flight_ff;
      if (req_xfer && !rsp_xfer) begin
         in_flight_in = in_flight_ff + 1'b1;
      end else if (rsp_xfer && !req_xfer) begin
         in_flight_in = in_flight_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff <= '0;
      end else begin
         in_flight_ff <= in_flight_in;
      end
   end

   a_rsp_needs_req: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> in_flight_ff != '0)
      else $error("response without an outstanding reference");

   a_in_flight_bound: assert property (@(posedge clock) disable iff (reset)
      in_flight_ff <= OW'(MaxInFlight))
      else $error("more references in flight than the design can hold");

   a_full_blocks_req: assert property (@(posedge clock) disable iff (reset)
      in_flight_ff == OW'(MaxInFlight) |-> !req_chan.ready)
      else $error("reference accepted with queue and back end full");

   a_hit_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && $past(rsp_xfer) |->
         rsp_chan.hit_count + rsp_chan.miss_count ==
         $past(rsp_chan.hit_count) + $past(rsp_chan.miss_count) + 16'd1)
      else $error("totals did not advance by one reference");
endmodule

[rtl/apr_ram.sv]
`timescale 1ns / 1ps

module apr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 write_en,
   input  logic [AW-1:0]        write_addr,
   input  logic [WIDTH-1:0]     write_data,
   input  logic [AW-1:0]        read_addr,
   output logic [WIDTH-1:0]     read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;
endmodule

[rtl/apr_queue.sv]
`timescale 1ns / 1ps

module apr_queue #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

[rtl/apr_front.sv]
`timescale 1ns / 1ps

module apr_front import apr_pkg::*; #(
   parameter int MAX_FRAMES = DefaultMaxFrames,
   parameter int NW         = ((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1) + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   apr_req_if.sink              req_chan,
   input  logic                 csr_write_en,
   input  logic [CfgWidth-1:0]  csr_write_data,
   input  logic                 queue_full,
   output logic                 push,
   output logic [NW+PageWidth-1:0] push_data
);
   logic [CfgWidth-1:0] frames_ff, frames_in;
   logic [NW-1:0]       active_n;

   always_comb begin
      frames_in = csr_write_en ? csr_write_data : frames_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= FramesReset;
      end else begin
         frames_ff <= frames_in;
      end
   end

   // Out-of-range frame counts are clamped into one to MAX_FRAMES.
   always_comb begin
      if (frames_ff == '0) begin
         active_n = NW'(1);
      end else if (int'(frames_ff) > MAX_FRAMES) begin
         active_n = NW'(MAX_FRAMES);
      end else begin
         active_n = NW'(frames_ff);
      end
   end

   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;
   assign push_data      = {active_n, req_chan.page_id};
endmodule

[rtl/apr_back.sv]
`timescale 1ns / 1ps

module apr_back import apr_pkg::*; #(
   parameter int MAX_FRAMES = DefaultMaxFrames,
   parameter int IW         = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
   parameter int NW         = IW + 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_not_empty,
   input  logic [NW+PageWidth-1:0] q_data,
   output logic                    q_pop,
   output logic                    out_valid,
   output apr_result_type          out_result,
   input  logic                    out_ready
);
   localparam int EW = PageWidth + AgeWidth;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPDATE} state_type;

   state_type            state_ff, state_in;
   logic [PageWidth-1:0] page_ff, page_in;
   logic [NW-1:0]        n_ff, n_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic                 done_ff, done_in;
   logic                 found_ff, found_in;
   logic [IW-1:0]        chosen_ff, chosen_in;
   logic [AgeWidth-1:0]  min_ff, min_in;
   logic [CountWidth-1:0] hits_ff, hits_in;
   logic [CountWidth-1:0] misses_ff, misses_in;
   logic                 valid_ff [MAX_FRAMES];
   logic                 set_valid;
   logic                 out_vld_ff, out_vld_in;
   apr_result_type       out_ff, out_in;

   logic                 ram_we;
   logic [IW-1:0]        ram_waddr, ram_raddr;
   logic [EW-1:0]        ram_wdata, ram_rdata;
   logic [PageWidth-1:0] rd_page;
   logic [AgeWidth-1:0]  age_sh;
   logic                 last;
   logic                 slot_free;
   logic [IW+IndexWidth-1:0] chosen_ext;

   apr_ram #(.WIDTH(EW), .DEPTH(MAX_FRAMES)) u_frames (
      .clock      (clock),
      .write_en   (ram_we),
      .write_addr (ram_waddr),
      .write_data (ram_wdata),
      .read_addr  (ram_raddr),
      .read_data  (ram_rdata)
   );

   assign rd_page    = ram_rdata[EW-1:AgeWidth];
   assign age_sh     = {1'b0, ram_rdata[AgeWidth-1:1]};
   assign last       = ({1'b0, idx_ff} + NW'(1)) == n_ff;
   assign slot_free  = !out_vld_ff || out_ready;
   assign chosen_ext = {{IndexWidth{1'b0}}, chosen_ff};

   always_comb begin
      state_in   = state_ff;
      page_in    = page_ff;
      n_in       = n_ff;
      idx_in     = idx_ff;
      done_in    = done_ff;
      found_in   = found_ff;
      chosen_in  = chosen_ff;
      min_in     = min_ff;
      hits_in    = hits_ff;
      misses_in  = misses_ff;
      out_vld_in = out_vld_ff && !out_ready;
      out_in     = out_ff;
      set_valid  = 1'b0;
      q_pop      = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = idx_ff;
      ram_wdata  = {rd_page, age_sh};
      ram_raddr  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            // Entry zero is read here so that its data lands in the first scan cycle.
            if (q_not_empty) begin
               q_pop     = 1'b1;
               page_in   = q_data[PageWidth-1:0];
               n_in      = q_data[NW+PageWidth-1:PageWidth];
               idx_in    = '0;
               done_in   = 1'b0;
               found_in  = 1'b0;
               chosen_in = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Every frame in use is aged and written back, even after the choice is made.
            ram_we    = 1'b1;
            ram_raddr = idx_ff + 1'b1;
            if (!done_ff) begin
               if (!valid_ff[idx_ff]) begin
                  chosen_in = idx_ff;
                  done_in   = 1'b1;
               end else if (rd_page == page_ff) begin
                  chosen_in = idx_ff;
                  found_in  = 1'b1;
                  done_in   = 1'b1;
                  min_in    = age_sh;
               end else if (idx_ff == '0 || age_sh < min_ff) begin
                  chosen_in = idx_ff;
                  min_in    = age_sh;
               end
            end
            idx_in = idx_ff + 1'b1;
            if (last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            ram_waddr = chosen_ff;
            ram_wdata = found_ff ? {page_ff, min_ff | AgeTopBit} : {page_ff, AgeTopBit};
            if (slot_free) begin
               ram_we    = 1'b1;
               set_valid = !found_ff;
               if (found_ff) begin
                  hits_in = hits_ff + 1'b1;
               end else begin
                  misses_in = misses_ff + 1'b1;
               end
               out_vld_in         = 1'b1;
               out_in.hit         = found_ff;
               out_in.frame_index = chosen_ext[IndexWidth-1:0];
               out_in.hit_count   = hits_in;
               out_in.miss_count  = misses_in;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         hits_ff    <= '0;
         misses_ff  <= '0;
         out_vld_ff <= 1'b0;
         for (int i = 0; i < MAX_FRAMES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff   <= state_in;
         hits_ff    <= hits_in;
         misses_ff  <= misses_in;
         out_vld_ff <= out_vld_in;
         if (set_valid) begin
            valid_ff[chosen_ff] <= 1'b1;
         end
      end
      page_ff   <= page_in;
      n_ff      <= n_in;
      idx_ff    <= idx_in;
      done_ff   <= done_in;
      found_ff  <= found_in;
      chosen_ff <= chosen_in;
      min_ff    <= min_in;
      out_ff    <= out_in;
   end

   assign out_valid  = out_vld_ff;
   assign out_result = out_ff;
endmodule

[bench/apr_outcome_checker.sv]
`timescale 1ns / 1ps

module apr_outcome_checker import apr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [PageWidth-1:0] req_page_id,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  apr_result_type       rsp_result,
   input  logic                 csr_write_en,
   input  logic [CfgWidth-1:0]  csr_write_data,
   output int                   fail_count,
   output int                   outstanding
);

   localparam int NumFrames = DefaultMaxFrames;

   logic                  frame_used    [NumFrames];
   logic [PageWidth-1:0]  frame_page    [NumFrames];
   logic [AgeWidth-1:0]   frame_age     [NumFrames];
   logic [CountWidth-1:0] hits_seen;
   logic [CountWidth-1:0] misses_seen;
   logic [CfgWidth-1:0]   frame_setting;
   apr_result_type        pending_outcomes [$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
      fail_count++;
   endtask

   // Ages the frames in use, scans them in order and places the page.
   function automatic apr_result_type age_and_place(input logic [PageWidth-1:0] page);
      apr_result_type outcome;
      int             active;
      int             chosen;
      bit             found;
      bit             settled;
      active = int'(frame_setting);
      if (active < 1) active = 1;
      if (active > NumFrames) active = NumFrames;
      for (int i = 0; i < active; i++) frame_age[i] = frame_age[i] >> 1;
      chosen  = 0;
      found   = 1'b0;
      settled = 1'b0;
      for (int i = 0; i < active; i++) begin
         if (!settled) begin
            if (!frame_used[i]) begin
               chosen  = i;
               settled = 1'b1;
            end else if (frame_page[i] == page) begin
               chosen  = i;
               found   = 1'b1;
               settled = 1'b1;
            end else if (frame_age[i] < frame_age[chosen]) begin
               chosen = i;
            end
         end
      end
      if (found) begin
         hits_seen = hits_seen + 1'b1;
      end else begin
         frame_used[chosen] = 1'b1;
         frame_page[chosen] = page;
         frame_age[chosen]  = '0;
         misses_seen        = misses_seen + 1'b1;
      end
      frame_age[chosen] = frame_age[chosen] | AgeTopBit;
      outcome.hit         = found;
      outcome.frame_index = chosen[IndexWidth-1:0];
      outcome.hit_count   = hits_seen;
      outcome.miss_count  = misses_seen;
      return outcome;
   endfunction

   always @(posedge clock) begin
      apr_result_type want;
      if (reset) begin
         for (int i = 0; i < NumFrames; i++) begin
            frame_used[i] = 1'b0;
            frame_page[i] = '0;
            frame_age[i]  = '0;
         end
         hits_seen     = '0;
         misses_seen   = '0;
         frame_setting = FramesReset;
         pending_outcomes.delete();
      end else begin
         if (csr_write_en) frame_setting = csr_write_data;
         // The response side is checked before this edge's request is predicted,
         // so a response can never be matched with its own request's transfer.
         if (rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               flag_mismatch("response with no reference pending", 32'(rsp_result), 0);
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_result.hit !== want.hit)
                  flag_mismatch("hit", 32'(rsp_result.hit), 32'(want.hit));
               if (rsp_result.frame_index !== want.frame_index)
                  flag_mismatch("frame_index", 32'(rsp_result.frame_index),
                                32'(want.frame_index));
               if (rsp_result.hit_count !== want.hit_count)
                  flag_mismatch("hit_count", 32'(rsp_result.hit_count),
                                32'(want.hit_count));
               if (rsp_result.miss_count !== want.miss_count)
                  flag_mismatch("miss_count", 32'(rsp_result.miss_count),
                                32'(want.miss_count));
            end
         end
         if (req_valid && req_ready) pending_outcomes.push_back(age_and_place(req_page_id));
      end
      outstanding = pending_outcomes.size();
   end

endmodule

[bench/aging_page_replacement_tb.sv]
`timescale 1ns / 1ps

module aging_page_replacement_tb;
   import apr_pkg::*;

   localparam int CycleLimit = 300000;
   localparam int PhaseItems = 140;
   localparam int NumPhases  = 10;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_write_en;
   logic [CfgWidth-1:0] csr_write_data;
   bit                  calm;
   int                  fail_count;
   int                  outstanding;
   int                  cycle_count = 0;

   apr_req_if req_chan ();
   apr_rsp_if rsp_chan ();

   aging_page_replacement u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   apr_outcome_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_page_id    (req_chan.page_id),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_result     ({rsp_chan.hit, rsp_chan.frame_index, rsp_chan.hit_count,
                        rsp_chan.miss_count}),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .outstanding    (outstanding)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("[aging_page_replacement] ERROR");
         $finish;
      end
   end

   // The receiver stalls now and then, except during the calm stretch.
   always @(negedge clock) begin
      rsp_chan.ready = calm || ($urandom_range(99) >= 6);
   end

   // Called at a falling edge; returns at the falling edge after the transfer,
   // with valid still high so that the next reference can follow at once.
   task automatic send_page(input logic [PageWidth-1:0] page);
      while (!calm && $urandom_range(99) < 6) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid   = 1'b1;
      req_chan.page_id = page;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // The frame count changes only once every reference has been answered.
   task automatic write_frames(input logic [CfgWidth-1:0] setting);
      req_chan.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_write_en   = 1'b1;
      csr_write_data = setting;
      @(negedge clock);
      csr_write_en   = 1'b0;
   endtask

   task automatic run_directed();
      // Full frame count out of reset: field extremes and the first hits.
      send_page(16'h0000);
      send_page(16'hFFFF);
      send_page(16'h0000);
      send_page(16'hAAAA);
      send_page(16'h5555);
      send_page(16'hFFFF);
      send_page(16'h8000);
      // A count of zero acts as a single frame; the other frames are kept.
      write_frames(5'd0);
      send_page(16'h0001);
      send_page(16'h0001);
      send_page(16'h7FFF);
      // A count above the maximum acts as the maximum; old frames come back.
      write_frames(5'd31);
      send_page(16'hAAAA);
      send_page(16'h7FFF);
      send_page(16'h1234);
      // Three frames: replacement by smallest age, ties to the lowest index.
      write_frames(5'd3);
      send_page(16'h4321);
      send_page(16'h1111);
      send_page(16'h2222);
      send_page(16'h4321);
      write_frames(5'd16);
      for (int i = 0; i < 8; i++) send_page(16'h0100 + 16'(i));
   endtask

   task automatic run_phase(input logic [CfgWidth-1:0] setting, input int count);
      logic [PageWidth-1:0] pool [20];
      logic [PageWidth-1:0] page;
      logic [PageWidth-1:0] last_page;
      int                   active;
      int                   pool_size;
      int                   pick;
      write_frames(setting);
      active = int'(setting);
      if (active < 1) active = 1;
      if (active > DefaultMaxFrames) active = DefaultMaxFrames;
      // A working set a little larger than the frames gives hits and evictions.
      pool_size = active + $urandom_range(0, 3);
      foreach (pool[i]) pool[i] = PageWidth'($urandom);
      last_page = pool[0];
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 65) page = pool[$urandom_range(pool_size - 1)];
         else if (pick < 80) page = last_page;
         else page = PageWidth'($urandom);
         send_page(page);
         last_page = page;
      end
   endtask

   initial begin
      logic [CfgWidth-1:0] phase_setting [NumPhases];
      phase_setting = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2, 5'd16, 5'd8, 5'd5, 5'd15, 5'd3};
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.page_id = '0;
      rsp_chan.ready   = 1'b0;
      csr_write_en     = 1'b0;
      csr_write_data   = '0;
      calm             = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      run_directed();
      for (int p = 0; p < NumPhases; p++) begin
         calm = (p == 5);
         run_phase(phase_setting[p], PhaseItems);
      end
      calm           = 1'b0;
      req_chan.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0) begin
         $display("[aging_page_replacement] OK");
      end else begin
         $display("[aging_page_replacement] ERROR");
      end
      $finish;
   end

endmodule
